FILE: src/assert_macros.svh
// Assertion helpers used by bitmap_set_engine_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define BSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define BSE_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/bse_pkg.sv
package bse_pkg;

  // Command codes of the input word.
  localparam logic [2:0] CMD_ADD       = 3'd0;
  localparam logic [2:0] CMD_REMOVE    = 3'd1;
  localparam logic [2:0] CMD_TEST      = 3'd2;
  localparam logic [2:0] CMD_FIND_FIRST = 3'd3;
  localparam logic [2:0] CMD_FIND_NEXT = 3'd4;
  localparam logic [2:0] CMD_COUNT     = 3'd5;

  // Status codes of the result word.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_CHECK,
    S_SCAN,
    S_TRIM_RD,
    S_TRIM,
    S_POST
  } state_t;

endpackage

FILE: src/bse_ram.sv
module bse_ram
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 32)
  (input  logic                                  clk,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/bitmap_set_engine_core.sv
// From accept to result: add and test pass S_ISSUE, S_CHECK and S_POST; remove goes on
// through S_TRIM_RD and S_TRIM, which cuts the length while the top word is zero (an absent
// ID goes from S_CHECK to S_POST); find first and find next read words in S_SCAN until a
// hit or the last word; count, out-of-range and no-op go straight to S_POST. Throughput:
// one word at a time; the next word is taken once the result is registered. Reset (rst_n low,
// synchronous) clears count and length; a clearing pass then zeroes the bitmap, in_stall high.
`include "assert_macros.svh"
module bitmap_set_engine_core
  import bse_pkg::*;
  #(parameter int MAX_IDS = 256,
    parameter int WORD_BITS = 8)
  (input  logic       clk,
   input  logic       rst_n,
   input  logic       in_valid,
   output logic       in_stall,
   input  logic [2:0] in_command,
   input  logic [7:0] in_item_id,
   output logic       out_valid,
   input  logic       out_stall,
   output logic [2:0] out_status,
   output logic       out_is_member,
   output logic [7:0] out_found_id,
   output logic [8:0] out_member_total,
   output logic [5:0] out_used_bytes);

  localparam int NUM_WORDS = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LEN_W     = $clog2(NUM_WORDS + 1);
  localparam int POP_W     = $clog2(MAX_IDS + 1);
  localparam int ID_W      = $clog2(MAX_IDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int DIV_SH    = 18;
  localparam int RECIP     = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;

  state_t            state_r, state_nxt;
  logic [WA_W-1:0]   clr_r, clr_nxt;
  logic [LEN_W-1:0]  used_r, used_nxt;
  logic [POP_W-1:0]  pop_r, pop_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [8:0]        id_r, id_nxt;
  logic [WA_W-1:0]   word_r, word_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [2:0]        status_r, status_nxt;
  logic              member_r, member_nxt;
  logic [ID_W-1:0]   found_r, found_nxt;

  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic              out_member_r;
  logic [7:0]        out_found_r;
  logic [8:0]        out_total_r;
  logic [5:0]        out_used_r;
  logic              post_load;

  logic                 wr_en;
  logic [WA_W-1:0]      wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WA_W-1:0]      rd_addr;
  logic [WORD_BITS-1:0] rd_data;

  // Word index of an ID by multiplying with the reciprocal of the word width.
  logic [8:0]        div_in;
  logic [24:0]       div_prod;
  logic [WA_W-1:0]   div_quot;
  logic              id_ok;
  logic              next_ok;

  // Bit offset inside the addressed word.
  logic [15:0]       word_base;
  logic [BIT_W-1:0]  bit_off;

  // Lowest set bit of the current word at or above the start offset.
  logic [WORD_BITS-1:0] bit_sel;
  logic [WORD_BITS-1:0] scan_bits;
  logic [BIT_W-1:0]     low_idx;
  logic                 low_hit;
  logic [LEN_W-1:0]     used_dec;
  logic [LEN_W-1:0]     add_len;

  bse_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_bitmap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Divider input: the start point of a search, or the ID itself.
  always_comb begin
    case (in_command)
      CMD_FIND_FIRST: div_in = 9'd0;
      CMD_FIND_NEXT:  div_in = 9'(in_item_id) + 9'd1;
      default:        div_in = 9'(in_item_id);
    endcase
    div_prod = 25'(div_in) * 25'(RECIP);
    div_quot = WA_W'(div_prod >> DIV_SH);
    id_ok    = (32'(in_item_id) < MAX_IDS);
    next_ok  = (32'(in_item_id) + 32'd1 < MAX_IDS);
  end

  always_comb begin
    word_base = 16'(word_r) * 16'(WORD_BITS);
    bit_off   = BIT_W'(16'(id_r) - word_base);
  end

  // Priority encoder over the masked word.
  always_comb begin
    bit_sel   = WORD_BITS'(1) << bit_r;
    scan_bits = rd_data & ({WORD_BITS{1'b1}} << bit_r);
    low_idx   = '0;
    low_hit   = 1'b0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (scan_bits[i]) begin
        low_idx = BIT_W'(i);
        low_hit = 1'b1;
      end
    end
    used_dec = used_r - LEN_W'(1);
    add_len  = LEN_W'(word_r) + LEN_W'(1);
  end

  // Sequencer: next state, memory accesses and result fields.
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    used_nxt   = used_r;
    pop_nxt    = pop_r;
    cmd_nxt    = cmd_r;
    id_nxt     = id_r;
    word_nxt   = word_r;
    bit_nxt    = bit_r;
    status_nxt = status_r;
    member_nxt = member_r;
    found_nxt  = found_r;
    wr_en      = 1'b0;
    wr_addr    = word_r;
    wr_data    = '0;
    rd_addr    = word_r;
    post_load  = 1'b0;
    in_stall   = (state_r != S_IDLE);

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        if (clr_r == WA_W'(NUM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + WA_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          id_nxt     = div_in;
          word_nxt   = div_quot;
          status_nxt = ST_OK;
          member_nxt = 1'b0;
          found_nxt  = '0;
          case (in_command)
            CMD_ADD, CMD_REMOVE, CMD_TEST: begin
              if (id_ok) begin
                state_nxt = S_ISSUE;
              end else begin
                status_nxt = ST_RANGE;
                state_nxt  = S_POST;
              end
            end
            CMD_FIND_FIRST: begin
              state_nxt = S_ISSUE;
            end
            CMD_FIND_NEXT: begin
              if (next_ok) begin
                state_nxt = S_ISSUE;
              end else begin
                status_nxt = ST_NONE;
                state_nxt  = S_POST;
              end
            end
            default: begin
              state_nxt = S_POST;
            end
          endcase
        end
      end
      S_ISSUE: begin
        // The read of word_r goes out here; the data arrives next cycle.
        bit_nxt = bit_off;
        if (cmd_r == CMD_FIND_FIRST || cmd_r == CMD_FIND_NEXT) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        case (cmd_r)
          CMD_ADD: begin
            if ((rd_data & bit_sel) != '0) begin
              status_nxt = ST_PRESENT;
            end else begin
              wr_en   = 1'b1;
              wr_data = rd_data | bit_sel;
              pop_nxt = pop_r + POP_W'(1);
              if (add_len > used_r) begin
                used_nxt = add_len;
              end
            end
            state_nxt = S_POST;
          end
          CMD_REMOVE: begin
            if ((rd_data & bit_sel) == '0) begin
              status_nxt = ST_ABSENT;
              state_nxt  = S_POST;
            end else begin
              wr_en     = 1'b1;
              wr_data   = rd_data & ~bit_sel;
              pop_nxt   = pop_r - POP_W'(1);
              state_nxt = S_TRIM_RD;
            end
          end
          default: begin
            member_nxt = ((rd_data & bit_sel) != '0);
            state_nxt  = S_POST;
          end
        endcase
      end
      S_SCAN: begin
        if (low_hit) begin
          found_nxt = ID_W'(ID_W'(word_r) * ID_W'(WORD_BITS)) + ID_W'(low_idx);
          state_nxt = S_POST;
        end else if (word_r == WA_W'(NUM_WORDS - 1)) begin
          status_nxt = ST_NONE;
          state_nxt  = S_POST;
        end else begin
          word_nxt = word_r + WA_W'(1);
          bit_nxt  = '0;
          rd_addr  = word_r + WA_W'(1);
        end
      end
      S_TRIM_RD: begin
        // The write-back landed last cycle, so this read sees the new word.
        rd_addr   = WA_W'(used_dec);
        state_nxt = S_TRIM;
      end
      S_TRIM: begin
        if (rd_data == '0 && used_r != '0) begin
          used_nxt = used_dec;
          rd_addr  = WA_W'(used_dec - LEN_W'(1));
          if (used_dec == '0) begin
            state_nxt = S_POST;
          end
        end else begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (!out_valid_r || !out_stall) begin
          post_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      pop_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      used_r  <= used_nxt;
      pop_r   <= pop_nxt;
      if (post_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working fields and the output register.
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    id_r     <= id_nxt;
    word_r   <= word_nxt;
    bit_r    <= bit_nxt;
    status_r <= status_nxt;
    member_r <= member_nxt;
    found_r  <= found_nxt;
    if (post_load) begin
      out_status_r <= status_r;
      out_member_r <= member_r;
      out_found_r  <= 8'(found_r);
      out_total_r  <= 9'(pop_r);
      out_used_r   <= 6'(used_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_is_member    = out_member_r;
  assign out_found_id     = out_found_r;
  assign out_member_total = out_total_r;
  assign out_used_bytes   = out_used_r;

  // An empty set has zero length and a nonempty one does not.
  `BSE_ASSERT(a_len_pop, (state_r == S_IDLE) |-> ((pop_r == '0) == (used_r == '0)), "length and count disagree")
  // The bitmap is written only by the clearing pass or a read-modify-write.
  `BSE_ASSERT(a_write_state, wr_en |-> (state_r == S_CLEAR || state_r == S_CHECK), "write outside update")
  // An accepted word always starts work and blocks the next one.
  `BSE_ASSERT(a_accept_busy, (in_valid && !in_stall) |=> (state_r != S_IDLE), "accept did not start work")
  // Length never exceeds the bitmap size.
  `BSE_NEVER(a_len_bound, 32'(used_r) > NUM_WORDS, "used length beyond bitmap")

endmodule
